// ===== src/lr_expression_parser_top_defines.svh =====
// Assertion macros shared by the parser controller and datapath.
// No dependencies; include guarded.
`ifndef LR_EXPRESSION_PARSER_TOP_DEFINES_SVH
`define LR_EXPRESSION_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define LRP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrp: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define LRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrp: next-cycle check failed");

`endif

// ===== src/lrp_pkg.sv =====
// Shared types, constants and the SLR(1) action/goto table of the parser.
// No dependencies.
`default_nettype none

package lrp_pkg;

    localparam int STACK_DEPTH  = 64;
    localparam int POSITION_MAX = 1023;
    localparam int PTR_W        = $clog2(STACK_DEPTH);
    localparam int POS_W        = $clog2(POSITION_MAX + 1);
    localparam int ERRPOS_W     = 10;

    // Terminals plus the nonterminal column; BAD marks an unknown character.
    typedef enum logic [2:0] {
        SYM_LPAR,
        SYM_ID,
        SYM_PLUS,
        SYM_STAR,
        SYM_RPAR,
        SYM_END,
        SYM_E,
        SYM_BAD
    } t_sym;

    typedef enum logic [1:0] {
        RS_ACCEPTED = 2'd0,
        RS_SYNTAX   = 2'd1,
        RS_OVERFLOW = 2'd2
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_GOTO
    } t_ctrl_state;

    typedef enum logic [1:0] {
        EK_SHIFT,
        EK_REDUCE,
        EK_RESULT
    } t_eval_kind;

    // Action codes: 0 accept, 1..9 shift/goto target, 11..13 reduce by 3,
    // 14 reduce by 1, anything else is no action.
    localparam logic [3:0] ACT_ACCEPT    = 4'd0;
    localparam logic [3:0] ACT_SHIFT_MAX = 4'd9;
    localparam logic [3:0] ACT_RED3_LO   = 4'd11;
    localparam logic [3:0] ACT_RED3_HI   = 4'd13;
    localparam logic [3:0] ACT_RED1      = 4'd14;
    localparam logic [3:0] ACT_NONE      = 4'd15;

    localparam logic [7:0] CH_LPAR = 8'h28;
    localparam logic [7:0] CH_RPAR = 8'h29;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_HASH = 8'h23;

    typedef struct packed {
        logic take_item;
        logic do_shift;
        logic do_reduce;
        logic do_goto_push;
        logic do_result_eval;
        logic do_result_goto;
    } t_dp_cmd;

    typedef struct packed {
        logic       parse_needed;
        t_eval_kind eval_kind;
        logic       goto_push;
        logic       out_free;
    } t_dp_status;

    function automatic logic is_alnum(logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic t_sym classify(logic [7:0] c, logic end_mark);
        t_sym s;
        if (end_mark || c == CH_HASH) begin
            s = SYM_END;
        end else if (is_alnum(c)) begin
            s = SYM_ID;
        end else begin
            unique case (c)
                CH_LPAR: s = SYM_LPAR;
                CH_RPAR: s = SYM_RPAR;
                CH_PLUS: s = SYM_PLUS;
                CH_STAR: s = SYM_STAR;
                default: s = SYM_BAD;
            endcase
        end
        return s;
    endfunction

    // Columns: ( i + * ) # E
    function automatic logic [3:0] act_lookup(logic [3:0] st, t_sym sym);
        logic [3:0] a;
        a = ACT_NONE;
        unique case (st)
            4'd0, 4'd2, 4'd4, 4'd5: begin
                case (sym) inside
                    SYM_LPAR: a = 4'd2;
                    SYM_ID:   a = 4'd3;
                    SYM_E: begin
                        case (st) inside
                            4'd0:    a = 4'd1;
                            4'd2:    a = 4'd6;
                            4'd4:    a = 4'd7;
                            default: a = 4'd8;
                        endcase
                    end
                    default:  a = ACT_NONE;
                endcase
            end
            4'd1: begin
                case (sym) inside
                    SYM_PLUS: a = 4'd4;
                    SYM_STAR: a = 4'd5;
                    SYM_END:  a = ACT_ACCEPT;
                    default:  a = ACT_NONE;
                endcase
            end
            4'd3: begin
                case (sym) inside
                    SYM_PLUS, SYM_STAR, SYM_RPAR, SYM_END: a = ACT_RED1;
                    default: a = ACT_NONE;
                endcase
            end
            4'd6: begin
                case (sym) inside
                    SYM_PLUS: a = 4'd4;
                    SYM_STAR: a = 4'd5;
                    SYM_RPAR: a = 4'd9;
                    default:  a = ACT_NONE;
                endcase
            end
            4'd7: begin
                case (sym) inside
                    SYM_STAR:                    a = 4'd5;
                    SYM_PLUS, SYM_RPAR, SYM_END: a = 4'd11;
                    default:                     a = ACT_NONE;
                endcase
            end
            4'd8: begin
                case (sym) inside
                    SYM_PLUS, SYM_STAR, SYM_RPAR, SYM_END: a = 4'd12;
                    default: a = ACT_NONE;
                endcase
            end
            4'd9: begin
                case (sym) inside
                    SYM_PLUS, SYM_STAR, SYM_RPAR, SYM_END: a = 4'd13;
                    default: a = ACT_NONE;
                endcase
            end
            default: a = ACT_NONE;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== src/lrp_in_if.sv =====
// Input channel: one character or end mark per item.
// No dependencies.
`default_nettype none

interface lrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_mark;

    modport source (output valid, output ch, output end_mark, input ready);
    modport sink   (input valid, input ch, input end_mark, output ready);
endinterface

`default_nettype wire

// ===== src/lrp_out_if.sv =====
// Output channel: one parse result per item.
// No dependencies.
`default_nettype none

interface lrp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [9:0] error_position;

    modport source (output valid, output status, output error_position, input ready);
    modport sink   (input valid, input status, input error_position, output ready);
endinterface

`default_nettype wire

// ===== src/lrp_ctrl.sv =====
// Parser sequencer: accept, evaluate action, pop/goto, emit result.
// Depends on lrp_pkg and lr_expression_parser_top_defines.svh.
`default_nettype none
`include "lr_expression_parser_top_defines.svh"

module lrp_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire lrp_pkg::t_dp_status i_status,
    output logic                    o_in_ready,
    output lrp_pkg::t_dp_cmd        o_cmd
);

    lrp_pkg::t_ctrl_state r_state;
    lrp_pkg::t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lrp_pkg::ST_IDLE: begin
                if (i_in_valid && i_status.parse_needed) n_state = lrp_pkg::ST_EVAL;
            end
            lrp_pkg::ST_EVAL: begin
                unique case (i_status.eval_kind)
                    lrp_pkg::EK_SHIFT:  n_state = lrp_pkg::ST_IDLE;
                    lrp_pkg::EK_REDUCE: n_state = lrp_pkg::ST_GOTO;
                    lrp_pkg::EK_RESULT: begin
                        if (i_status.out_free) n_state = lrp_pkg::ST_IDLE;
                    end
                    default:            n_state = lrp_pkg::ST_IDLE;
                endcase
            end
            lrp_pkg::ST_GOTO: begin
                if (i_status.goto_push) begin
                    n_state = lrp_pkg::ST_EVAL;
                end else if (i_status.out_free) begin
                    n_state = lrp_pkg::ST_IDLE;
                end
            end
            default: n_state = lrp_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            lrp_pkg::ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.take_item = i_in_valid;
            end
            lrp_pkg::ST_EVAL: begin
                unique case (i_status.eval_kind)
                    lrp_pkg::EK_SHIFT:  o_cmd.do_shift       = 1'b1;
                    lrp_pkg::EK_REDUCE: o_cmd.do_reduce      = 1'b1;
                    lrp_pkg::EK_RESULT: o_cmd.do_result_eval = i_status.out_free;
                    default:            o_cmd                = '0;
                endcase
            end
            lrp_pkg::ST_GOTO: begin
                o_cmd.do_goto_push   = i_status.goto_push;
                o_cmd.do_result_goto = !i_status.goto_push && i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    `LRP_ASSERT_NEXT(a_reduce_to_goto, i_clk, i_rst_n, o_cmd.do_reduce,
        r_state == lrp_pkg::ST_GOTO)
    `LRP_ASSERT_NEXT(a_push_to_eval, i_clk, i_rst_n, o_cmd.do_goto_push,
        r_state == lrp_pkg::ST_EVAL)
    `LRP_ASSERT_NOW(a_goto_after_eval, i_clk, i_rst_n, r_state == lrp_pkg::ST_GOTO,
        $past(r_state) == lrp_pkg::ST_EVAL || $past(r_state) == lrp_pkg::ST_GOTO)

endmodule

`default_nettype wire

// ===== src/lrp_dpath.sv =====
// Parser datapath: state stack memory, top-of-stack register, position
// counter, identifier tracking and the result register.
// Depends on lrp_pkg and lr_expression_parser_top_defines.svh.
`default_nettype none
`include "lr_expression_parser_top_defines.svh"

module lrp_dpath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lrp_pkg::t_dp_cmd              i_cmd,
    input  wire logic [7:0]                    i_ch,
    input  wire logic                          i_end_mark,
    input  wire logic                          i_out_ready,
    output lrp_pkg::t_dp_status                o_status,
    output logic                               o_out_valid,
    output logic [1:0]                         o_out_status,
    output logic [lrp_pkg::ERRPOS_W-1:0]       o_out_error_position
);

    localparam logic [lrp_pkg::PTR_W-1:0] TOP_MAX = lrp_pkg::PTR_W'(lrp_pkg::STACK_DEPTH - 1);
    localparam logic [lrp_pkg::POS_W-1:0] POS_MAX = lrp_pkg::POS_W'(lrp_pkg::POSITION_MAX);

    // stack entries; entry zero is never written and reads as state 0
    logic [3:0] r_stack_mem [lrp_pkg::STACK_DEPTH];
    logic [3:0] r_rd_data;

    logic [lrp_pkg::PTR_W-1:0] r_top, n_top;
    logic [3:0]                r_tos, n_tos;
    logic [lrp_pkg::POS_W-1:0] r_pos, n_pos;
    logic                      r_in_id, n_in_id;
    logic                      r_finished, n_finished;
    lrp_pkg::t_sym             r_sym, n_sym;
    logic                      r_end, n_end;
    logic                      r_out_valid, n_out_valid;
    logic [1:0]                r_out_status, n_out_status;
    logic [lrp_pkg::ERRPOS_W-1:0] r_out_pos, n_out_pos;

    lrp_pkg::t_sym             in_sym;
    logic                      in_end;
    logic [3:0]                act_e;
    logic                      act_shift, act_red3, act_red1, act_accept;
    logic [lrp_pkg::PTR_W-1:0] pop_cnt;
    logic                      at_max;
    logic                      underflow;
    lrp_pkg::t_result          eval_code;
    logic [3:0]                goto_src;
    logic [3:0]                goto_st;
    logic                      goto_ok;
    lrp_pkg::t_result          goto_code;
    logic [lrp_pkg::PTR_W-1:0] rd_addr;
    logic                      wr_en;
    logic [3:0]                wr_data;
    logic                      out_free;

    // input classification
    assign in_sym = lrp_pkg::classify(i_ch, i_end_mark);
    assign in_end = (in_sym == lrp_pkg::SYM_END);

    // action lookup on the current top of stack
    assign act_e      = lrp_pkg::act_lookup(r_tos, r_sym);
    assign act_accept = (act_e == lrp_pkg::ACT_ACCEPT);
    assign act_shift  = (act_e != lrp_pkg::ACT_ACCEPT) && (act_e <= lrp_pkg::ACT_SHIFT_MAX);
    assign act_red3   = (act_e >= lrp_pkg::ACT_RED3_LO) && (act_e <= lrp_pkg::ACT_RED3_HI);
    assign act_red1   = (act_e == lrp_pkg::ACT_RED1);
    assign pop_cnt    = act_red3 ? lrp_pkg::PTR_W'(3) : lrp_pkg::PTR_W'(1);
    assign at_max     = (r_top == TOP_MAX);
    assign underflow  = (r_top < pop_cnt);
    assign rd_addr    = r_top - pop_cnt;

    always_comb begin
        if (act_accept && r_sym != lrp_pkg::SYM_BAD) begin
            eval_code = lrp_pkg::RS_ACCEPTED;
        end else if (act_shift && r_sym != lrp_pkg::SYM_BAD) begin
            eval_code = lrp_pkg::RS_OVERFLOW;
        end else begin
            eval_code = lrp_pkg::RS_SYNTAX;
        end
    end

    // goto after a pop; r_top already holds the popped top
    assign goto_src  = (r_top == '0) ? 4'd0 : r_rd_data;
    assign goto_st   = lrp_pkg::act_lookup(goto_src, lrp_pkg::SYM_E);
    assign goto_ok   = (goto_st != lrp_pkg::ACT_ACCEPT) && (goto_st <= lrp_pkg::ACT_SHIFT_MAX);
    assign goto_code = goto_ok ? lrp_pkg::RS_OVERFLOW : lrp_pkg::RS_SYNTAX;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_status.parse_needed = !r_finished && !(in_sym == lrp_pkg::SYM_ID && r_in_id);
        o_status.out_free     = out_free;
        o_status.goto_push    = goto_ok && !at_max;
        if (r_sym == lrp_pkg::SYM_BAD) begin
            o_status.eval_kind = lrp_pkg::EK_RESULT;
        end else if (act_shift && !at_max) begin
            o_status.eval_kind = lrp_pkg::EK_SHIFT;
        end else if ((act_red3 || act_red1) && !underflow) begin
            o_status.eval_kind = lrp_pkg::EK_REDUCE;
        end else begin
            o_status.eval_kind = lrp_pkg::EK_RESULT;
        end
    end

    // stack write port
    assign wr_en   = i_cmd.do_shift || i_cmd.do_goto_push;
    assign wr_data = i_cmd.do_shift ? act_e : goto_st;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_stack_mem[r_top + lrp_pkg::PTR_W'(1)] <= wr_data;
        end
        r_rd_data <= r_stack_mem[rd_addr];
    end

    always_comb begin
        n_top        = r_top;
        n_tos        = r_tos;
        n_pos        = r_pos;
        n_in_id      = r_in_id;
        n_finished   = r_finished;
        n_sym        = r_sym;
        n_end        = r_end;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_pos    = r_out_pos;

        if (i_cmd.take_item) begin
            if (r_pos < POS_MAX) n_pos = r_pos + lrp_pkg::POS_W'(1);
            n_sym = in_sym;
            n_end = in_end;
            if (r_finished) begin
                if (in_end) begin
                    n_top      = '0;
                    n_tos      = 4'd0;
                    n_in_id    = 1'b0;
                    n_pos      = '0;
                    n_finished = 1'b0;
                end
            end else begin
                n_in_id = (in_sym == lrp_pkg::SYM_ID);
            end
        end

        if (i_cmd.do_shift || i_cmd.do_goto_push) begin
            n_top = r_top + lrp_pkg::PTR_W'(1);
            n_tos = wr_data;
        end

        if (i_cmd.do_reduce) begin
            n_top = rd_addr;
        end

        if (i_cmd.do_result_eval || i_cmd.do_result_goto) begin
            n_out_valid  = 1'b1;
            n_out_status = i_cmd.do_result_eval ? eval_code : goto_code;
            if (i_cmd.do_result_eval && eval_code == lrp_pkg::RS_ACCEPTED) begin
                n_out_pos = '0;
            end else begin
                n_out_pos = lrp_pkg::ERRPOS_W'(r_pos);
            end
            if (r_end || (i_cmd.do_result_eval && eval_code == lrp_pkg::RS_ACCEPTED)) begin
                n_top      = '0;
                n_tos      = 4'd0;
                n_in_id    = 1'b0;
                n_pos      = '0;
                n_finished = 1'b0;
            end else begin
                n_finished = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top       <= '0;
            r_tos       <= 4'd0;
            r_pos       <= '0;
            r_in_id     <= 1'b0;
            r_finished  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_top       <= n_top;
            r_tos       <= n_tos;
            r_pos       <= n_pos;
            r_in_id     <= n_in_id;
            r_finished  <= n_finished;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym        <= n_sym;
        r_end        <= n_end;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
    end

    assign o_out_valid          = r_out_valid;
    assign o_out_status         = r_out_status;
    assign o_out_error_position = r_out_pos;

    `LRP_ASSERT_NOW(a_result_slot_free, i_clk, i_rst_n,
        i_cmd.do_result_eval || i_cmd.do_result_goto, out_free)
    `LRP_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, i_cmd.do_shift || i_cmd.do_goto_push,
        r_top == $past(r_top) + lrp_pkg::PTR_W'(1) && r_tos != 4'd0)
    `LRP_ASSERT_NEXT(a_result_clears_or_ends, i_clk, i_rst_n,
        i_cmd.do_result_eval || i_cmd.do_result_goto,
        r_out_valid && (r_finished || r_top == '0))

endmodule

`default_nettype wire

// ===== src/lr_expression_parser_top.sv =====
// A character that shifts directly goes through accept and evaluate; each reduction it
// triggers adds a stack pop read and a goto push. Result is registered.
// A new character is taken only once the previous one has shifted or produced its result;
// absorbed identifier and ignored characters skip evaluation. Stack memory read port sets the pop cost.
// Reset: synchronous, active low; empty stack, position 0, no result pending, no clearing pass.
// Depends on lrp_pkg, lrp_in_if, lrp_out_if, lrp_ctrl and lrp_dpath.
`default_nettype none

module lr_expression_parser_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lrp_in_if.sink    i_in,
    lrp_out_if.source o_out
);

    // controller <-> datapath handshake groups
    lrp_pkg::t_dp_cmd    cmd;
    lrp_pkg::t_dp_status status;
    logic                in_ready;

    // Controller: IDLE takes items, EVAL looks up the action for the held
    // symbol, GOTO finishes a reduction with the goto push. Results wait in
    // the datapath's output register; EVAL/GOTO only stall when a new result
    // is due while the previous one has not been taken.
    lrp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    // Datapath: state stack in a single-port-write, registered-read memory,
    // top-of-stack kept in a register so shifts need no memory read.
    lrp_dpath u_dpath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .i_ch                 (i_in.ch),
        .i_end_mark           (i_in.end_mark),
        .i_out_ready          (o_out.ready),
        .o_status             (status),
        .o_out_valid          (o_out.valid),
        .o_out_status         (o_out.status),
        .o_out_error_position (o_out.error_position)
    );

    assign i_in.ready = in_ready;

endmodule

`default_nettype wire

// ===== bench/lrp_parse_monitor.sv =====
`timescale 1ns / 100ps
// Watches both channels of lr_expression_parser_top, predicts every parse verdict and
// checks each result item against it. Depends on lrp_pkg, lrp_in_if and lrp_out_if.
module lrp_parse_monitor (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lrp_in_if         i_chars,
    lrp_out_if        i_verdicts,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_parsed_chars,
    output int        o_accepted,
    output int        o_syntax_errors,
    output int        o_overflows
);
    import lrp_pkg::*;

    typedef struct packed {
        t_result    status;
        logic [9:0] position;
    } parse_verdict_t;

    typedef enum {PO_SHIFTED, PO_SYNTAX, PO_OVERFLOW, PO_ACCEPT} parse_outcome_t;

    localparam int unsigned REPORT_CAP = 200;

    // Reduce codes by production; shift and goto targets are plain state numbers.
    localparam logic [3:0] NA      = ACT_NONE;
    localparam logic [3:0] R_SUM   = ACT_RED3_LO;   // E -> E+E
    localparam logic [3:0] R_PROD  = 4'd12;         // E -> E*E
    localparam logic [3:0] R_PAREN = ACT_RED3_HI;   // E -> (E)
    localparam logic [3:0] R_ID    = ACT_RED1;      // E -> i

    // Rows are parser states, columns ( i + * ) # E.
    localparam logic [0:9][0:6][3:0] SLR_ACTIONS = {
        {4'd2, 4'd3, NA,      NA,      NA,      NA,         4'd1},
        {NA,   NA,   4'd4,    4'd5,    NA,      ACT_ACCEPT, NA  },
        {4'd2, 4'd3, NA,      NA,      NA,      NA,         4'd6},
        {NA,   NA,   R_ID,    R_ID,    R_ID,    R_ID,       NA  },
        {4'd2, 4'd3, NA,      NA,      NA,      NA,         4'd7},
        {4'd2, 4'd3, NA,      NA,      NA,      NA,         4'd8},
        {NA,   NA,   4'd4,    4'd5,    4'd9,    NA,         NA  },
        {NA,   NA,   R_SUM,   4'd5,    R_SUM,   R_SUM,      NA  },
        {NA,   NA,   R_PROD,  R_PROD,  R_PROD,  R_PROD,     NA  },
        {NA,   NA,   R_PAREN, R_PAREN, R_PAREN, R_PAREN,    NA  }
    };

    logic [3:0]     parse_stack [STACK_DEPTH];
    int unsigned    stack_ptr;
    bit             in_ident;
    bit             halted;
    int unsigned    char_pos;
    parse_verdict_t verdicts_due [$];
    int             fail_total;
    int             parsed_total;
    int             accept_total;
    int             syntax_total;
    int             overflow_total;

    task automatic report_mismatch(input string what);
        if (fail_total < REPORT_CAP)
            $display("%0t ns: mismatch: %s", $time, what);
        fail_total++;
    endtask

    function automatic void clear_parser();
        foreach (parse_stack[k]) parse_stack[k] = '0;
        stack_ptr = 0;
        in_ident  = 1'b0;
        char_pos  = 0;
        halted    = 1'b0;
    endfunction

    function automatic logic [3:0] action_of(t_sym sym);
        logic [3:0] st;
        st = parse_stack[stack_ptr % STACK_DEPTH];
        if (st > 4'd9 || sym > SYM_E)
            return ACT_NONE;
        return SLR_ACTIONS[st][sym];
    endfunction

    // Reduce until the symbol shifts, the input is accepted or the parse fails.
    function automatic parse_outcome_t run_symbol(t_sym sym);
        logic [3:0]  act;
        logic [3:0]  tgt;
        int unsigned pop;
        if (sym == SYM_BAD)
            return PO_SYNTAX;
        for (int guard = 0; guard < 2 * STACK_DEPTH + 8; guard++) begin
            act = action_of(sym);
            if (act == ACT_NONE)
                return PO_SYNTAX;
            if (act == ACT_ACCEPT)
                return PO_ACCEPT;
            if (act <= ACT_SHIFT_MAX) begin
                if (stack_ptr + 1 >= STACK_DEPTH)
                    return PO_OVERFLOW;
                stack_ptr++;
                parse_stack[stack_ptr] = act;
                return PO_SHIFTED;
            end
            pop = (act >= ACT_RED3_LO && act <= ACT_RED3_HI) ? 3 : 1;
            if (stack_ptr < pop)
                return PO_SYNTAX;
            stack_ptr -= pop;
            tgt = action_of(SYM_E);
            if (tgt == ACT_NONE || tgt == ACT_ACCEPT || tgt > ACT_SHIFT_MAX)
                return PO_SYNTAX;
            if (stack_ptr + 1 >= STACK_DEPTH)
                return PO_OVERFLOW;
            stack_ptr++;
            parse_stack[stack_ptr] = tgt;
        end
        return PO_SYNTAX;
    endfunction

    function automatic void predict_char(logic [7:0] c, logic end_mark);
        bit             is_end;
        t_sym           sym;
        parse_outcome_t po;
        parse_verdict_t v;
        is_end = end_mark || c == CH_HASH;
        if (char_pos < POSITION_MAX)
            char_pos++;
        if (halted) begin
            if (is_end)
                clear_parser();
            return;
        end
        parsed_total++;
        if (is_end) begin
            sym      = SYM_END;
            in_ident = 1'b0;
        end else if ((c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
                     (c >= "A" && c <= "Z")) begin
            // later characters of an identifier are absorbed
            if (in_ident)
                return;
            in_ident = 1'b1;
            sym      = SYM_ID;
        end else begin
            in_ident = 1'b0;
            case (c)
                CH_LPAR: sym = SYM_LPAR;
                CH_RPAR: sym = SYM_RPAR;
                CH_PLUS: sym = SYM_PLUS;
                CH_STAR: sym = SYM_STAR;
                default: sym = SYM_BAD;
            endcase
        end
        po = run_symbol(sym);
        if (po == PO_SHIFTED)
            return;
        if (po == PO_ACCEPT) begin
            v.status   = RS_ACCEPTED;
            v.position = '0;
            verdicts_due.push_back(v);
            accept_total++;
            clear_parser();
            return;
        end
        v.status   = (po == PO_OVERFLOW) ? RS_OVERFLOW : RS_SYNTAX;
        v.position = 10'(char_pos);
        verdicts_due.push_back(v);
        if (po == PO_OVERFLOW)
            overflow_total++;
        else
            syntax_total++;
        if (is_end)
            clear_parser();
        else
            halted = 1'b1;
    endfunction

    always @(posedge i_clk) begin : watch
        parse_verdict_t want;
        if (!i_rst_n) begin
            clear_parser();
            verdicts_due.delete();
        end else begin
            if (i_verdicts.valid && i_verdicts.ready) begin
                if (verdicts_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result status=%0d position=%0d",
                                              i_verdicts.status, i_verdicts.error_position));
                end else begin
                    want = verdicts_due.pop_front();
                    if (i_verdicts.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %s",
                                                  i_verdicts.status, want.status.name()));
                    if (i_verdicts.error_position !== want.position)
                        report_mismatch($sformatf("error_position %0d, expected %0d",
                                                  i_verdicts.error_position, want.position));
                end
            end
            if (i_chars.valid && i_chars.ready)
                predict_char(i_chars.ch, i_chars.end_mark);
        end
        o_pending       <= verdicts_due.size();
        o_fail_count    <= fail_total;
        o_parsed_chars  <= parsed_total;
        o_accepted      <= accept_total;
        o_syntax_errors <= syntax_total;
        o_overflows     <= overflow_total;
    end

endmodule

// ===== bench/tb_lr_expression_parser_top.sv =====
`timescale 1ns / 100ps
// Stimulus and verdict for lr_expression_parser_top: directed expressions, then random
// well-formed, broken and noise expressions. Depends on lrp_pkg, both channel
// interfaces, the block itself and lrp_parse_monitor.
module tb_lr_expression_parser_top;
    import lrp_pkg::*;

    localparam int unsigned HALF_PERIOD    = 6;
    localparam int unsigned IDLE_PCT       = 9;
    // Items sent over the whole run, directed part included.
    localparam int          TOTAL_ITEMS    = 1950;
    // A result can trail its character by a long reduction chain.
    localparam int unsigned DRAIN_CYCLES   = 200;
    // A normal run needs a small fraction of this.
    localparam int unsigned TIMEOUT_CYCLES = 600_000;

    logic i_clk;
    logic i_rst_n;

    lrp_in_if  in_chan ();
    lrp_out_if out_chan ();

    int fail_count;
    int pending_verdicts;
    int parsed_chars;
    int accepted_count;
    int syntax_count;
    int overflow_count;

    // While set, neither side inserts idle cycles.
    bit calm;
    int sent_chars;
    int expr_count;

    lr_expression_parser_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_chan),
        .o_out   (out_chan)
    );

    lrp_parse_monitor u_parse_monitor (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_chars         (in_chan),
        .i_verdicts      (out_chan),
        .o_fail_count    (fail_count),
        .o_pending       (pending_verdicts),
        .o_parsed_chars  (parsed_chars),
        .o_accepted      (accepted_count),
        .o_syntax_errors (syntax_count),
        .o_overflows     (overflow_count)
    );

    always begin
        i_clk = 1'b0;
        #(HALF_PERIOD);
        i_clk = 1'b1;
        #(HALF_PERIOD);
    end

    // Result side: stalls at random, except in the calm stretch.
    always @(posedge i_clk) begin
        out_chan.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Hands one character to the block. valid stays high between back-to-back
    // items; a random gap drops it for whole cycles only.
    task automatic push_item(input logic [7:0] c, input logic end_mark);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_chan.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_chan.valid    <= 1'b1;
        in_chan.ch       <= c;
        in_chan.end_mark <= end_mark;
        @(posedge i_clk);
        while (!in_chan.ready)
            @(posedge i_clk);
        sent_chars++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_item(s[i], 1'b0);
    endtask

    // Holds the input off until every predicted result has come out. The first
    // edge lets the monitor's count catch up with the last handshake.
    task automatic wait_all_results();
        in_chan.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_verdicts != 0)
            @(posedge i_clk);
    endtask

    // Random well-formed expression of bounded nesting: identifiers of 1..4
    // characters drawn from digits, lower and upper case.
    function automatic void grow_expr(ref logic [7:0] q[$], input int unsigned depth);
        int unsigned pick;
        int unsigned len;
        pick = $urandom_range(0, 9);
        if (depth == 0 || pick < 4) begin
            len = $urandom_range(1, 4);
            repeat (len) begin
                case ($urandom_range(0, 2))
                    0:       q.push_back(8'($urandom_range("9", "0")));
                    1:       q.push_back(8'($urandom_range("z", "a")));
                    default: q.push_back(8'($urandom_range("Z", "A")));
                endcase
            end
        end else if (pick < 6) begin
            q.push_back(CH_LPAR);
            grow_expr(q, depth - 1);
            q.push_back(CH_RPAR);
        end else begin
            grow_expr(q, depth - 1);
            q.push_back(($urandom_range(0, 1) != 0) ? CH_PLUS : CH_STAR);
            grow_expr(q, depth - 1);
        end
    endfunction

    initial begin : stimulus
        logic [7:0]  expr_q [$];
        int unsigned flavor;
        int unsigned nest;
        int unsigned spot;
        string       id_run;

        calm             = 1'b0;
        in_chan.valid    <= 1'b0;
        in_chan.ch       <= '0;
        in_chan.end_mark <= 1'b0;
        i_rst_n          <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part ----
        // single identifier, end mark with an all-ones character that must be ignored
        push_text("a");
        push_item(8'hFF, 1'b1);
        // empty expression: error at the end mark itself
        push_item(8'h00, 1'b1);
        // digit and letter extremes, both operators, parentheses, literal hash as end
        push_text("(Zz9+0)*A");
        push_item(CH_HASH, 1'b0);
        // operator after operator; the trailing 'b' is ignored, end mark gives nothing
        push_text("a+*b");
        push_item(8'h5A, 1'b1);
        // identifier right after ')': reported at its first character
        push_text("(a)bc");
        push_item(8'h00, 1'b1);
        // unknown character (space), then an end mark that also carries '#'
        push_text("a b");
        push_item(CH_HASH, 1'b1);
        // expression cut short at the hash, unbalanced parentheses, stray ')'
        push_text("a+");
        push_item(CH_HASH, 1'b0);
        push_text("((a)");
        push_item(8'h80, 1'b1);
        push_text(")");
        push_item(8'h7F, 1'b1);
        // character codes at both ends of the range are unknown characters
        push_text("b*");
        push_item(8'hFF, 1'b0);
        push_item(8'h01, 1'b1);
        push_item(8'h00, 1'b0);
        push_item(8'h00, 1'b1);

        // stack overflow: the 64th open parenthesis does not fit
        repeat (64) push_item(CH_LPAR, 1'b0);
        push_item(8'h00, 1'b1);

        // position saturation: one identifier longer than the position counter,
        // then an error that must report the saturated position
        id_run = "09azAZqm5Q";
        push_text("a");
        for (int i = 0; i < 1030; i++)
            push_item(id_run[i % id_run.len()], 1'b0);
        push_item(CH_RPAR, 1'b0);
        push_item(8'h00, 1'b1);
        // position must start again from one after the clear
        push_text("a*b+c");
        push_item(8'h00, 1'b1);
        wait_all_results();

        // ---- random part ----
        // Mostly well-formed expressions, some with one edit, some pure noise,
        // a few nested deep enough to reach the stack limit.
        expr_count = 0;
        while (sent_chars < TOTAL_ITEMS) begin
            calm = (expr_count >= 10 && expr_count < 30);
            expr_q.delete();
            flavor = $urandom_range(0, 99);
            if (flavor < 12) begin
                repeat ($urandom_range(1, 6))
                    expr_q.push_back(8'($urandom_range(0, 255)));
            end else if (flavor < 17) begin
                nest = $urandom_range(50, 66);
                repeat (nest) expr_q.push_back(CH_LPAR);
                grow_expr(expr_q, 1);
                repeat (nest) expr_q.push_back(CH_RPAR);
            end else begin
                grow_expr(expr_q, $urandom_range(0, 4));
                if (flavor < 32) begin
                    // one edit: overwrite, insert or drop a character
                    spot = $urandom_range(0, expr_q.size() - 1);
                    case ($urandom_range(0, 2))
                        0:       expr_q[spot] = 8'($urandom_range(0, 255));
                        1:       expr_q.insert(spot, 8'($urandom_range(0, 255)));
                        default: expr_q.delete(spot);
                    endcase
                end
            end
            foreach (expr_q[i])
                push_item(expr_q[i], 1'b0);
            if ($urandom_range(0, 4) == 0)
                push_item(CH_HASH, 1'b0);
            else
                push_item(8'($urandom_range(0, 255)), 1'b1);
            expr_count++;
            // every so often the source pauses until the block is drained
            if (expr_count % 15 == 0)
                wait_all_results();
        end
        calm = 1'b0;

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Fed %0d characters (%0d reached the parser): directed cases plus %0d %s",
                 sent_chars, parsed_chars, expr_count, "random expressions.");
        $display("Verdicts: %0d accepted, %0d syntax errors, %0d stack overflows.",
                 accepted_count, syntax_count, overflow_count);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Hard stop in case the block hangs or a result never arrives.
    initial begin
        #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
        $display("Timeout with %0d results still pending.", pending_verdicts);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
